[hdl/bitmap_id_allocator_assert.svh]
// assertion macros for the bitmap id allocator
// used by the controller and datapath files; no dependencies
`ifndef BITMAP_ID_ALLOCATOR_ASSERT_SVH
`define BITMAP_ID_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define BIA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bitmap id allocator check failed");
`define BIA_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("bitmap id allocator forbidden condition");
`else
`define BIA_ASSERT(lbl, clk, rstn, prop)
`define BIA_NEVER(lbl, clk, rstn, expr)
`endif

`endif

[hdl/bia_pkg.sv]
// shared types and constants for the bitmap id allocator
// no dependencies
package bia_pkg;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam int ID_W   = 16;
  localparam int CNT_W  = 7;

  localparam logic [ID_W-1:0]  BASE_ID_RST    = 16'd0;
  localparam logic [ID_W-1:0]  TOP_ID_RST     = 16'd63;
  localparam logic [CNT_W-1:0] MAX_ACTIVE_RST = 7'd50;

  typedef enum logic [1:0] {
    REG_BASE_ID    = 2'd0,
    REG_TOP_ID     = 2'd1,
    REG_MAX_ACTIVE = 2'd2
  } bia_reg_e;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_CLEAR = 2'd2
  } bia_req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LIMIT = 2'd1,
    ST_FULL  = 2'd2,
    ST_BADID = 2'd3
  } bia_status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_SCAN = 2'd2
  } bia_state_e;

  typedef struct packed {
    logic [ID_W-1:0]  base_id;
    logic [ID_W-1:0]  top_id;
    logic [CNT_W-1:0] max_active;
  } bia_cfg_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic grant;
    logic full;
    logic next;
  } bia_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       limit_hit;
    logic       found;
    logic       last_chunk;
    logic       out_free;
  } bia_stat_t;

endpackage

[hdl/bitmap_id_allocator.sv]
// bitmap id allocator: free, clear and limit-refused allocate results are registered
// from the exec state, searching allocates from the scan state, which walks the bitmap
// one chunk of up to 64 slots at a time; a result is registered only once any pending
// result has been taken (out_ready_i), and the next transaction is taken in the cycle
// after a result is registered, so requests never overlap. asynchronous active-low reset
// empties the bitmap, zeroes the in-use count and loads the register defaults (0, 63, 50)
module bitmap_id_allocator #(
  parameter int NUM_SLOTS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bia_pkg::CFG_AW-1:0]   paddr,
  input  logic [bia_pkg::CFG_DW-1:0]   pwdata,
  output logic [bia_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   req_type_i,
  input  logic [bia_pkg::ID_W-1:0]     free_id_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bia_pkg::ID_W-1:0]     granted_id_o,
  output logic [1:0]                   status_o
);
  import bia_pkg::*;

  bia_cfg_t  cfg;
  bia_cmd_t  cmd;
  bia_stat_t stat;

  bia_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bia_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bia_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .req_type_i   (req_type_i),
    .free_id_i    (free_id_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .granted_id_o (granted_id_o),
    .status_o     (status_o)
  );

endmodule

[hdl/bia_regs.sv]
// configuration register file with apb-style access
// depends on bia_pkg
module bia_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bia_pkg::CFG_AW-1:0]   paddr,
  input  logic [bia_pkg::CFG_DW-1:0]   pwdata,
  output logic [bia_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready,
  output bia_pkg::bia_cfg_t            cfg_o
);
  import bia_pkg::*;

  logic [ID_W-1:0]  base_id_q, base_id_d;
  logic [ID_W-1:0]  top_id_q, top_id_d;
  logic [CNT_W-1:0] max_active_q, max_active_d;
  logic             wr_en;
  bia_reg_e         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = bia_reg_e'(paddr[3:2]);

  always_comb begin
    base_id_d    = base_id_q;
    top_id_d     = top_id_q;
    max_active_d = max_active_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_BASE_ID:    base_id_d    = pwdata[ID_W-1:0];
        REG_TOP_ID:     top_id_d     = pwdata[ID_W-1:0];
        REG_MAX_ACTIVE: max_active_d = pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BASE_ID:    prdata = CFG_DW'(base_id_q);
      REG_TOP_ID:     prdata = CFG_DW'(top_id_q);
      REG_MAX_ACTIVE: prdata = CFG_DW'(max_active_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_id_q    <= BASE_ID_RST;
      top_id_q     <= TOP_ID_RST;
      max_active_q <= MAX_ACTIVE_RST;
    end else begin
      base_id_q    <= base_id_d;
      top_id_q     <= top_id_d;
      max_active_q <= max_active_d;
    end
  end

  assign cfg_o.base_id    = base_id_q;
  assign cfg_o.top_id     = top_id_q;
  assign cfg_o.max_active = max_active_q;

endmodule

[hdl/bia_ctrl.sv]
// request sequencer for the bitmap id allocator
// depends on bia_pkg and bitmap_id_allocator_assert.svh
`include "bitmap_id_allocator_assert.svh"
module bia_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bia_pkg::bia_stat_t stat_i,
  output bia_pkg::bia_cmd_t  cmd_o
);
  import bia_pkg::*;

  bia_state_e state_q, state_d;
  logic       to_scan;

  assign to_scan = (stat_i.req == REQ_ALLOC) && !stat_i.limit_hit;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (to_scan) state_d = S_SCAN;
        else if (stat_i.out_free) state_d = S_IDLE;
      end
      S_SCAN: begin
        if ((stat_i.found || stat_i.last_chunk) && stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.exec = !to_scan && stat_i.out_free;
      end
      S_SCAN: begin
        cmd_o.grant = stat_i.found && stat_i.out_free;
        cmd_o.full  = !stat_i.found && stat_i.last_chunk && stat_i.out_free;
        cmd_o.next  = !stat_i.found && !stat_i.last_chunk;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `BIA_ASSERT(a_cmd_excl, clk_i, rst_ni, $onehot0(cmd_o))
  `BIA_ASSERT(a_finish_free, clk_i, rst_ni, (cmd_o.exec || cmd_o.grant || cmd_o.full) |-> stat_i.out_free)
  `BIA_ASSERT(a_load_on_accept, clk_i, rst_ni, cmd_o.load == (in_valid_i && in_ready_o))

endmodule

[hdl/bia_dp.sv]
// bitmap, counters, chunked free-slot search and result register
// depends on bia_pkg and bitmap_id_allocator_assert.svh
`include "bitmap_id_allocator_assert.svh"
module bia_dp #(
  parameter int NUM_SLOTS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bia_pkg::bia_cfg_t          cfg_i,
  input  bia_pkg::bia_cmd_t          cmd_i,
  output bia_pkg::bia_stat_t         stat_o,
  input  logic [1:0]                 req_type_i,
  input  logic [bia_pkg::ID_W-1:0]   free_id_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [bia_pkg::ID_W-1:0]   granted_id_o,
  output logic [1:0]                 status_o
);
  import bia_pkg::*;

  localparam int CW   = (NUM_SLOTS < 64) ? NUM_SLOTS : 64;
  localparam int NCH  = (NUM_SLOTS + CW - 1) / CW;
  localparam int MAPW = NCH * CW;
  localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int IW   = $clog2(CW);
  localparam int MIW  = $clog2(MAPW);
  localparam int LW   = $clog2(NUM_SLOTS + 1);
  localparam logic [CHW-1:0] LAST_CHUNK = CHW'(NCH - 1);

  logic [MAPW-1:0]  map_q, map_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CHW-1:0]   chunk_q, chunk_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       req_q, req_d;
  logic [ID_W-1:0]  fid_q, fid_d;
  logic [LW-1:0]    len_q, len_d;
  logic [ID_W-1:0]  gid_q, gid_d;
  bia_status_e      stat_q, stat_d;

  logic [ID_W-1:0]  cfg_diff;
  logic [LW-1:0]    len_n;
  logic [CW-1:0]    chunk_w;
  logic [CW-1:0]    avail;
  logic [LW:0]      cbase;
  logic             found;
  logic [IW-1:0]    idx;
  logic [MIW-1:0]   gslot;
  logic [ID_W-1:0]  fdiff;
  logic             free_ok;

  // clamped range length from the live registers
  always_comb begin
    cfg_diff = cfg_i.top_id - cfg_i.base_id;
    if (cfg_i.top_id < cfg_i.base_id) begin
      len_n = '0;
    end else if ({1'b0, cfg_diff} >= 17'(NUM_SLOTS)) begin
      len_n = LW'(NUM_SLOTS);
    end else begin
      len_n = LW'({1'b0, cfg_diff} + 17'd1);
    end
  end

  // lowest free in-range slot of the current chunk
  always_comb begin
    chunk_w = map_q[int'(chunk_q) * CW +: CW];
    cbase   = (LW + 1)'(int'(chunk_q) * CW);
    found   = 1'b0;
    idx     = '0;
    for (int i = 0; i < CW; i++) begin
      avail[i] = !chunk_w[i] && ((cbase + (LW + 1)'(i)) < {1'b0, len_q});
    end
    for (int i = CW - 1; i >= 0; i--) begin
      if (avail[i]) begin
        found = 1'b1;
        idx   = IW'(i);
      end
    end
    gslot = MIW'(cbase) + MIW'(idx);
  end

  always_comb begin
    fdiff   = fid_q - cfg_i.base_id;
    free_ok = (fid_q >= cfg_i.base_id) && (fid_q <= cfg_i.top_id) &&
              ({1'b0, fdiff} < 17'(len_q)) && map_q[fdiff[MIW-1:0]];
  end

  always_comb begin
    map_d       = map_q;
    cnt_d       = cnt_q;
    chunk_d     = chunk_q;
    req_d       = req_q;
    fid_d       = fid_q;
    len_d       = len_q;
    gid_d       = gid_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.load) begin
      req_d   = req_type_i;
      fid_d   = free_id_i;
      len_d   = len_n;
      chunk_d = '0;
    end

    if (cmd_i.next) begin
      chunk_d = chunk_q + CHW'(1);
    end

    if (cmd_i.exec) begin
      out_valid_d = 1'b1;
      gid_d       = '0;
      unique case (bia_req_e'(req_q))
        REQ_ALLOC: stat_d = ST_LIMIT;
        REQ_FREE: begin
          if (free_ok) begin
            map_d[fdiff[MIW-1:0]] = 1'b0;
            cnt_d                 = cnt_q - CNT_W'(1);
            stat_d                = ST_OK;
          end else begin
            stat_d = ST_BADID;
          end
        end
        REQ_CLEAR: begin
          map_d  = '0;
          cnt_d  = '0;
          stat_d = ST_OK;
        end
        default: stat_d = ST_BADID;
      endcase
    end

    if (cmd_i.grant) begin
      map_d[gslot] = 1'b1;
      cnt_d        = cnt_q + CNT_W'(1);
      gid_d        = cfg_i.base_id + ID_W'(gslot);
      stat_d       = ST_OK;
      out_valid_d  = 1'b1;
    end

    if (cmd_i.full) begin
      gid_d       = '0;
      stat_d      = ST_FULL;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q       <= '0;
      cnt_q       <= '0;
      chunk_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      map_q       <= map_d;
      cnt_q       <= cnt_d;
      chunk_q     <= chunk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    fid_q  <= fid_d;
    len_q  <= len_d;
    gid_q  <= gid_d;
    stat_q <= stat_d;
  end

  assign stat_o.req        = req_q;
  assign stat_o.limit_hit  = cnt_q >= cfg_i.max_active;
  assign stat_o.found      = found;
  assign stat_o.last_chunk = chunk_q == LAST_CHUNK;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign granted_id_o = gid_q;
  assign status_o     = stat_q;

  `BIA_ASSERT(a_cnt_matches_map, clk_i, rst_ni, cnt_q == CNT_W'($countones(map_q)))
  `BIA_NEVER(a_grant_used_slot, clk_i, rst_ni, cmd_i.grant && map_q[gslot])
  `BIA_ASSERT(a_clear_empties, clk_i, rst_ni, (cmd_i.exec && req_q == REQ_CLEAR) |=> (map_q == '0))

endmodule

[tb/tb_top.sv]
// self-checking testbench for bitmap_id_allocator: valid/ready request and result
// channels, apb register writes between phases, in-line prediction of every result
// depends on bia_pkg and the bitmap_id_allocator rtl only
module tb_top;
  import bia_pkg::*;

  localparam int NUM_SLOTS = 64;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int NUM_PHASES = 18;
  localparam int RAND_PER_PHASE = 72;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]      req;
    logic [ID_W-1:0] id;
  } id_request_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [1:0]      status;
  } id_grant_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        req_type_i = REQ_ALLOC;
  logic [ID_W-1:0]   free_id_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [ID_W-1:0]   granted_id_o;
  logic [1:0]        status_o;

  bitmap_id_allocator #(
    .NUM_SLOTS(NUM_SLOTS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .free_id_i   (free_id_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .granted_id_o(granted_id_o),
    .status_o    (status_o)
  );

  // predictor state and register copies
  logic [NUM_SLOTS-1:0] used_slots = '0;
  logic [CNT_W-1:0]     active_ids = '0;
  logic [ID_W-1:0]      win_base = BASE_ID_RST;
  logic [ID_W-1:0]      win_top = TOP_ID_RST;
  logic [CNT_W-1:0]     win_max = MAX_ACTIVE_RST;

  id_request_t request_q[$];
  id_grant_t   expected_grants[$];

  int  send_idle_pct = 33;
  int  recv_idle_pct = 72;
  int  phase_no = 0;
  int  error_count = 0;
  int  requests_done = 0;
  int  grants_ok = 0;
  int  limit_hits = 0;
  int  full_hits = 0;
  int  rejects = 0;
  bit  in_fire = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(string what, int got, int want);
    if (error_count < 50)
      $display("mismatch: %s, got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic int window_len();
    int len;
    len = (win_top < win_base) ? 0 : int'(win_top) - int'(win_base) + 1;
    return (len > NUM_SLOTS) ? NUM_SLOTS : len;
  endfunction

  function automatic id_grant_t predict_grant(id_request_t rq);
    id_grant_t g;
    int len;
    int off;
    g.id = '0;
    g.status = ST_OK;
    len = window_len();
    off = int'(rq.id) - int'(win_base);
    case (rq.req)
      REQ_ALLOC: begin
        if (active_ids >= win_max) begin
          g.status = ST_LIMIT;
        end else begin
          g.status = ST_FULL;
          for (int s = 0; s < len && g.status == ST_FULL; s++) begin
            if (!used_slots[s]) begin
              used_slots[s] = 1'b1;
              active_ids = active_ids + 1'b1;
              g.id = ID_W'(int'(win_base) + s);
              g.status = ST_OK;
            end
          end
        end
      end
      REQ_FREE: begin
        if (off < 0 || rq.id > win_top || off >= len || !used_slots[off]) begin
          g.status = ST_BADID;
        end else begin
          used_slots[off] = 1'b0;
          active_ids = active_ids - 1'b1;
        end
      end
      REQ_CLEAR: begin
        used_slots = '0;
        active_ids = '0;
      end
      default: g.status = ST_BADID;
    endcase
    return g;
  endfunction

  // monitor: results first, then newly accepted requests
  always @(posedge clk_i) begin : monitor
    id_grant_t want;
    id_grant_t pred;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_grants.size() == 0) begin
          report_mismatch("result with nothing outstanding", granted_id_o, 0);
        end else begin
          want = expected_grants.pop_front();
          if (granted_id_o !== want.id)
            report_mismatch("granted_id", granted_id_o, want.id);
          if (status_o !== want.status)
            report_mismatch("status", status_o, want.status);
        end
      end
      in_fire = in_valid_i && in_ready_o;
      if (in_fire) begin
        pred = predict_grant('{req: req_type_i, id: free_id_i});
        expected_grants.push_back(pred);
        requests_done++;
        case (pred.status)
          ST_OK:    if (req_type_i == REQ_ALLOC) grants_ok++;
          ST_LIMIT: limit_hits++;
          ST_FULL:  full_hits++;
          default:  rejects++;
        endcase
      end
    end else begin
      in_fire = 1'b0;
    end
  end

  // driver: requests and result back-pressure change on the falling edge
  always @(negedge clk_i) begin : driver
    id_request_t rq;
    if (!in_valid_i || in_fire) begin
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        rq = request_q.pop_front();
        req_type_i <= rq.req;
        free_id_i  <= rq.id;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic cfg_write(bia_reg_e r, logic [CFG_DW-1:0] v);
    logic [CFG_DW-1:0] mask;
    mask = (r == REG_MAX_ACTIVE) ? CFG_DW'(7'h7f) : CFG_DW'(16'hffff);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (r)
      REG_BASE_ID:    win_base = v[ID_W-1:0];
      REG_TOP_ID:     win_top = v[ID_W-1:0];
      REG_MAX_ACTIVE: win_max = v[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if ((prdata & mask) !== (v & mask))
      report_mismatch("register readback", prdata & mask, v & mask);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_window(int b, int t, int m);
    int regime;
    phase_no++;
    regime = phase_no * 3 / NUM_PHASES;
    send_idle_pct = (regime == 0) ? 33 : (regime == 1) ? 72 : 0;
    recv_idle_pct = (regime == 0) ? 72 : (regime == 1) ? 33 : 0;
    cfg_write(REG_BASE_ID, CFG_DW'(b));
    cfg_write(REG_TOP_ID, CFG_DW'(t));
    cfg_write(REG_MAX_ACTIVE, CFG_DW'(m));
  endtask

  function automatic void push_request(logic [1:0] r, int id);
    request_q.push_back('{req: r, id: ID_W'(id)});
  endfunction

  task automatic add_random(int n);
    int len;
    int sel;
    int id;
    len = window_len();
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      id = $urandom_range(65535);
      if (sel < 45) begin
        push_request(REQ_ALLOC, id);
      end else if (sel < 80) begin
        if (len > 0) id = int'(win_base) + $urandom_range(len - 1);
        push_request(REQ_FREE, id);
      end else if (sel < 86) begin
        push_request(REQ_FREE, id);
      end else if (sel < 90) begin
        if ($urandom_range(1) == 0 && win_top < 16'hffff) id = int'(win_top) + 1;
        else if (win_base > 0) id = int'(win_base) - 1;
        else if (int'(win_base) + NUM_SLOTS <= 65535) id = int'(win_base) + NUM_SLOTS;
        push_request(REQ_FREE, id);
      end else if (sel < 95) begin
        push_request(REQ_CLEAR, id);
      end else begin
        push_request(REQ_UNKNOWN, id);
      end
    end
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    while ((request_q.size() != 0 || in_valid_i || expected_grants.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    if (waited >= DRAIN_LIMIT)
      report_mismatch("results outstanding after drain", expected_grants.size(), 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int b;
    int t;
    int m;
    int sel;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: range 0..63, limit 50
    push_request(REQ_ALLOC, 16'hffff);
    push_request(REQ_ALLOC, 0);
    push_request(REQ_FREE, 0);
    push_request(REQ_FREE, 0);
    push_request(REQ_FREE, 64);
    push_request(REQ_FREE, 16'hffff);
    push_request(REQ_UNKNOWN, 16'hffff);
    push_request(REQ_CLEAR, 16'h5a5a);
    push_request(REQ_ALLOC, 0);
    add_random(RAND_PER_PHASE);
    drain();

    // range wider than the bitmap
    set_window(0, 65535, 64);
    push_request(REQ_FREE, 64);
    push_request(REQ_FREE, 16'hffff);
    add_random(RAND_PER_PHASE);
    drain();

    // window at the top of the id space
    set_window(16'hffc0, 16'hffff, 64);
    push_request(REQ_CLEAR, 0);
    push_request(REQ_ALLOC, 0);
    push_request(REQ_FREE, 16'hffc0);
    push_request(REQ_FREE, 16'hffff);
    add_random(RAND_PER_PHASE);
    drain();

    // tiny window fills up, limit above the bitmap size
    set_window(1000, 1002, 127);
    push_request(REQ_CLEAR, 0);
    repeat (4) push_request(REQ_ALLOC, 0);
    add_random(RAND_PER_PHASE);
    drain();

    // empty range
    set_window(200, 100, 10);
    push_request(REQ_ALLOC, 0);
    push_request(REQ_FREE, 150);
    push_request(REQ_FREE, 100);
    push_request(REQ_FREE, 200);
    add_random(RAND_PER_PHASE);
    drain();

    // zero limit
    set_window(5, 40, 0);
    push_request(REQ_ALLOC, 0);
    add_random(RAND_PER_PHASE);
    drain();

    // single slot, limit of one
    set_window(0, 0, 1);
    push_request(REQ_CLEAR, 0);
    push_request(REQ_ALLOC, 0);
    push_request(REQ_ALLOC, 0);
    push_request(REQ_FREE, 0);
    add_random(RAND_PER_PHASE);
    drain();

    set_window(300, 363, 3);
    add_random(RAND_PER_PHASE);
    drain();

    for (int p = 0; p < NUM_PHASES - 8; p++) begin
      b = $urandom_range(65535);
      sel = $urandom_range(99);
      if (sel < 40) t = b + $urandom_range(15);
      else if (sel < 70) t = b + $urandom_range(80, 50);
      else if (sel < 85) t = 65535;
      else t = (b == 0) ? 0 : $urandom_range(b - 1);
      if (t > 65535) t = 65535;
      m = ($urandom_range(9) == 0) ? $urandom_range(127, 65) : $urandom_range(64);
      set_window(b, t, m);
      add_random(RAND_PER_PHASE);
      drain();
    end

    if (expected_grants.size() != 0)
      report_mismatch("results never delivered", expected_grants.size(), 0);
    $display("run covered %0d requests over %0d register settings", requests_done,
             phase_no + 1);
    $display("outcomes: %0d grants, %0d at limit, %0d range full, %0d rejected",
             grants_ok, limit_hits, full_hits, rejects);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
